// ===== rtl/wqmf_pkg.sv =====
// shared types, constants and helpers for the weighted quadratic mean filter
// used by the register bank, the controller, the datapath and the top level
package wqmf_pkg;

    localparam int unsigned CFG_W       = 17;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned NUM_W       = 4;
    localparam int unsigned SAMPLE_W    = 16;
    localparam int unsigned FILT_W      = 15;
    localparam int unsigned MET_W       = 24;
    localparam int unsigned SUM_W       = 48;
    localparam int unsigned ACC_W       = 50;
    localparam int unsigned SQ_W        = 33;
    localparam int unsigned PROD_W      = 48;
    localparam int unsigned MB_A_W      = 31;
    localparam int unsigned DIV_CNT_W   = 6;
    localparam int unsigned Q_SHIFT     = 16;
    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 88;
    localparam int unsigned OUT_TUSER_W = 2;
    localparam int unsigned FILT_SQRT_TOP = 32;
    localparam int unsigned WIDE_SQRT_TOP = 46;

    localparam logic [CFG_IDX_W-1:0] REG_W_CENTER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_W_OFF1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_W_OFF2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_W_OFF3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LAMBDA   = 3'd4;

    localparam logic [CFG_W-1:0] W_CENTER_RST = 17'd21845;
    localparam logic [CFG_W-1:0] W_OFF1_RST   = 17'd21845;
    localparam logic [CFG_W-1:0] W_OFF2_RST   = 17'd0;
    localparam logic [CFG_W-1:0] W_OFF3_RST   = 17'd0;
    localparam logic [CFG_W-1:0] LAMBDA_RST   = 17'd0;
    localparam logic [CFG_W-1:0] ONE_Q16      = 17'd65536;

    localparam logic [FILT_W-1:0] FILT_MAX   = '1;
    localparam logic [MET_W-1:0]  MET_MAX    = '1;
    localparam logic [ACC_W-1:0]  CRIT_ROUND = 50'd32768;

    typedef struct packed {
        logic [NUM_W-1:0][CFG_W-1:0] weight;
        logic [CFG_W-1:0]            lambda;
    } t_cfg;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_SQ, OP_WT, OP_ACC, OP_FSQRT_LD, OP_SQRT_STEP,
        OP_FILT_DONE, OP_DEV_SQ, OP_DEV_ADD, OP_RGH_ADD, OP_RSQRT_LD,
        OP_ROUGH_DONE, OP_DIV_LD, OP_DIV_STEP, OP_DSQRT_LD, OP_DEV_DONE,
        OP_CRIT1, OP_CRIT2, OP_CRIT3, OP_CRIT_DONE, OP_EMIT
    } t_dp_op;

    typedef enum logic [4:0] {
        S_IDLE, S_SQ, S_WT, S_ACC, S_FSQRT_LD, S_FSQRT, S_FILT_DONE,
        S_DEV_SQ, S_DEV_ADD, S_RGH_ADD, S_RSQRT_LD, S_RSQRT, S_ROUGH_DONE,
        S_DIV_LD, S_DIV, S_DSQRT_LD, S_DSQRT, S_DEV_DONE,
        S_CRIT1, S_CRIT2, S_CRIT3, S_CRIT_DONE, S_EMIT
    } t_state;

    typedef struct packed {
        logic tap_last;
        logic sqrt_done;
        logic div_done;
        logic full;
        logic last;
        logic acc_en;
        logic out_free;
    } t_dp_status;

    function automatic logic [SUM_W-1:0] sat_add48(input logic [SUM_W-1:0] a,
                                                   input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

endpackage

// ===== rtl/wqmf_cfg_regs.sv =====
// configuration register bank: tap weights and criterion blend
// depends on wqmf_pkg
module wqmf_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_we,
    input  logic [wqmf_pkg::CFG_IDX_W-1:0]      i_idx,
    input  logic [wqmf_pkg::CFG_W-1:0]          i_wdata,
    output wqmf_pkg::t_cfg                      o_cfg
);

    wqmf_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.weight[0] <= wqmf_pkg::W_CENTER_RST;
            r_cfg.weight[1] <= wqmf_pkg::W_OFF1_RST;
            r_cfg.weight[2] <= wqmf_pkg::W_OFF2_RST;
            r_cfg.weight[3] <= wqmf_pkg::W_OFF3_RST;
            r_cfg.lambda    <= wqmf_pkg::LAMBDA_RST;
        end else if (i_we) begin
            unique case (i_idx)
                wqmf_pkg::REG_W_CENTER: r_cfg.weight[0] <= i_wdata;
                wqmf_pkg::REG_W_OFF1:   r_cfg.weight[1] <= i_wdata;
                wqmf_pkg::REG_W_OFF2:   r_cfg.weight[2] <= i_wdata;
                wqmf_pkg::REG_W_OFF3:   r_cfg.weight[3] <= i_wdata;
                wqmf_pkg::REG_LAMBDA:   r_cfg.lambda    <= i_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/wqmf_ctrl.sv =====
// sequencing state machine: issues at most one datapath operation per cycle, none while waiting on input or output
// depends on wqmf_pkg
module wqmf_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  wqmf_pkg::t_dp_status    i_status,
    output logic                    o_in_ready,
    output wqmf_pkg::t_dp_op        o_op
);

    wqmf_pkg::t_state r_state;
    wqmf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wqmf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wqmf_pkg::S_IDLE: begin
                if (i_in_valid) n_state = wqmf_pkg::S_SQ;
            end
            wqmf_pkg::S_SQ:       n_state = wqmf_pkg::S_WT;
            wqmf_pkg::S_WT: begin
                n_state = i_status.tap_last ? wqmf_pkg::S_ACC : wqmf_pkg::S_SQ;
            end
            wqmf_pkg::S_ACC: begin
                n_state = i_status.full ? wqmf_pkg::S_FSQRT_LD : wqmf_pkg::S_EMIT;
            end
            wqmf_pkg::S_FSQRT_LD: n_state = wqmf_pkg::S_FSQRT;
            wqmf_pkg::S_FSQRT: begin
                if (i_status.sqrt_done) n_state = wqmf_pkg::S_FILT_DONE;
            end
            wqmf_pkg::S_FILT_DONE: begin
                priority if (i_status.acc_en) n_state = wqmf_pkg::S_DEV_SQ;
                else if (i_status.last)       n_state = wqmf_pkg::S_RSQRT_LD;
                else                          n_state = wqmf_pkg::S_EMIT;
            end
            wqmf_pkg::S_DEV_SQ:   n_state = wqmf_pkg::S_DEV_ADD;
            wqmf_pkg::S_DEV_ADD:  n_state = wqmf_pkg::S_RGH_ADD;
            wqmf_pkg::S_RGH_ADD: begin
                n_state = i_status.last ? wqmf_pkg::S_RSQRT_LD : wqmf_pkg::S_EMIT;
            end
            wqmf_pkg::S_RSQRT_LD: n_state = wqmf_pkg::S_RSQRT;
            wqmf_pkg::S_RSQRT: begin
                if (i_status.sqrt_done) n_state = wqmf_pkg::S_ROUGH_DONE;
            end
            wqmf_pkg::S_ROUGH_DONE: n_state = wqmf_pkg::S_DIV_LD;
            wqmf_pkg::S_DIV_LD:     n_state = wqmf_pkg::S_DIV;
            wqmf_pkg::S_DIV: begin
                if (i_status.div_done) n_state = wqmf_pkg::S_DSQRT_LD;
            end
            wqmf_pkg::S_DSQRT_LD: n_state = wqmf_pkg::S_DSQRT;
            wqmf_pkg::S_DSQRT: begin
                if (i_status.sqrt_done) n_state = wqmf_pkg::S_DEV_DONE;
            end
            wqmf_pkg::S_DEV_DONE:  n_state = wqmf_pkg::S_CRIT1;
            wqmf_pkg::S_CRIT1:     n_state = wqmf_pkg::S_CRIT2;
            wqmf_pkg::S_CRIT2:     n_state = wqmf_pkg::S_CRIT3;
            wqmf_pkg::S_CRIT3:     n_state = wqmf_pkg::S_CRIT_DONE;
            wqmf_pkg::S_CRIT_DONE: n_state = wqmf_pkg::S_EMIT;
            wqmf_pkg::S_EMIT: begin
                if (i_status.out_free) n_state = wqmf_pkg::S_IDLE;
            end
            default: n_state = wqmf_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_op       = wqmf_pkg::OP_NONE;
        unique case (r_state)
            wqmf_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_op = wqmf_pkg::OP_LOAD;
            end
            wqmf_pkg::S_SQ:       o_op = wqmf_pkg::OP_SQ;
            wqmf_pkg::S_WT:       o_op = wqmf_pkg::OP_WT;
            wqmf_pkg::S_ACC:      o_op = wqmf_pkg::OP_ACC;
            wqmf_pkg::S_FSQRT_LD: o_op = wqmf_pkg::OP_FSQRT_LD;
            wqmf_pkg::S_FSQRT, wqmf_pkg::S_RSQRT, wqmf_pkg::S_DSQRT: begin
                if (!i_status.sqrt_done) o_op = wqmf_pkg::OP_SQRT_STEP;
            end
            wqmf_pkg::S_FILT_DONE:  o_op = wqmf_pkg::OP_FILT_DONE;
            wqmf_pkg::S_DEV_SQ:     o_op = wqmf_pkg::OP_DEV_SQ;
            wqmf_pkg::S_DEV_ADD:    o_op = wqmf_pkg::OP_DEV_ADD;
            wqmf_pkg::S_RGH_ADD:    o_op = wqmf_pkg::OP_RGH_ADD;
            wqmf_pkg::S_RSQRT_LD:   o_op = wqmf_pkg::OP_RSQRT_LD;
            wqmf_pkg::S_ROUGH_DONE: o_op = wqmf_pkg::OP_ROUGH_DONE;
            wqmf_pkg::S_DIV_LD:     o_op = wqmf_pkg::OP_DIV_LD;
            wqmf_pkg::S_DIV: begin
                if (!i_status.div_done) o_op = wqmf_pkg::OP_DIV_STEP;
            end
            wqmf_pkg::S_DSQRT_LD:  o_op = wqmf_pkg::OP_DSQRT_LD;
            wqmf_pkg::S_DEV_DONE:  o_op = wqmf_pkg::OP_DEV_DONE;
            wqmf_pkg::S_CRIT1:     o_op = wqmf_pkg::OP_CRIT1;
            wqmf_pkg::S_CRIT2:     o_op = wqmf_pkg::OP_CRIT2;
            wqmf_pkg::S_CRIT3:     o_op = wqmf_pkg::OP_CRIT3;
            wqmf_pkg::S_CRIT_DONE: o_op = wqmf_pkg::OP_CRIT_DONE;
            wqmf_pkg::S_EMIT: begin
                if (i_status.out_free) o_op = wqmf_pkg::OP_EMIT;
            end
            default: o_op = wqmf_pkg::OP_NONE;
        endcase
    end

`ifndef SYNTHESIS
    a_metrics_only_on_full_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wqmf_pkg::S_RSQRT_LD) |-> (i_status.last && i_status.full))
        else $error("metric pass entered without a full window on the last request");
    a_emit_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wqmf_pkg::S_EMIT && i_status.out_free) |=> (r_state == wqmf_pkg::S_IDLE))
        else $error("result handed over but controller did not return to idle");
    a_accept_starts_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wqmf_pkg::S_IDLE && i_in_valid) |=> (r_state == wqmf_pkg::S_SQ))
        else $error("accepted request did not start the tap loop");
`endif

endmodule

// ===== rtl/wqmf_datapath.sv =====
// datapath: delay line, shared multipliers, iterative square root and divider,
// record sums and the output register; depends on wqmf_pkg
module wqmf_datapath #(
    parameter int unsigned TAPS        = 3,
    parameter int unsigned MAX_SAMPLES = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  wqmf_pkg::t_dp_op                    i_op,
    input  wqmf_pkg::t_cfg                      i_cfg,
    input  logic [wqmf_pkg::SAMPLE_W-1:0]       i_sample,
    input  logic                                i_last,
    input  logic                                i_out_ready,
    output wqmf_pkg::t_dp_status                o_status,
    output logic                                o_out_valid,
    output logic [wqmf_pkg::FILT_W-1:0]         o_filtered,
    output logic                                o_filt_valid,
    output logic                                o_met_valid,
    output logic [wqmf_pkg::MET_W-1:0]          o_rough,
    output logic [wqmf_pkg::MET_W-1:0]          o_dev,
    output logic [wqmf_pkg::MET_W-1:0]          o_crit
);

    localparam int unsigned HALF = (TAPS - 1) / 2;
    localparam int unsigned WIN  = 2 * HALF + 1;
    localparam int unsigned TW   = $clog2(WIN);
    localparam int unsigned CW   = $clog2(MAX_SAMPLES + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SAMPLES);
    localparam logic [CW-1:0] CNT_WIN = CW'(WIN);

    // record state
    logic signed [wqmf_pkg::SAMPLE_W-1:0] r_window [WIN-1];
    logic [CW-1:0]                        r_count;
    logic [wqmf_pkg::FILT_W-1:0]          r_prev;
    logic                                 r_prev_valid;
    logic [wqmf_pkg::SUM_W-1:0]           r_rsum;
    logic [wqmf_pkg::SUM_W-1:0]           r_dsum;
    logic                                 r_out_valid;

    // per-request working registers
    logic signed [wqmf_pkg::SAMPLE_W-1:0] r_sample;
    logic                                 r_last;
    logic                                 r_acc_en;
    logic                                 r_full;
    logic [CW-1:0]                        r_cnt_next;
    logic [TW-1:0]                        r_tap;
    logic [wqmf_pkg::SQ_W-1:0]            r_sq;
    logic [wqmf_pkg::PROD_W-1:0]          r_prod;
    logic [wqmf_pkg::ACC_W-1:0]           r_acc;
    logic [wqmf_pkg::SUM_W-1:0]           r_rad;
    logic [wqmf_pkg::SUM_W-1:0]           r_root;
    logic [wqmf_pkg::SUM_W-1:0]           r_bit;
    logic [wqmf_pkg::SUM_W-1:0]           r_quo;
    logic [CW-1:0]                        r_rem;
    logic [wqmf_pkg::DIV_CNT_W-1:0]       r_div_cnt;
    logic [wqmf_pkg::FILT_W-1:0]          r_y;
    logic [wqmf_pkg::MET_W-1:0]           r_rough;
    logic [wqmf_pkg::MET_W-1:0]           r_dev;
    logic [wqmf_pkg::MET_W-1:0]           r_crit;

    // output register
    logic [wqmf_pkg::FILT_W-1:0]          r_o_filt;
    logic                                 r_o_fvalid;
    logic                                 r_o_mvalid;
    logic [wqmf_pkg::MET_W-1:0]           r_o_rough;
    logic [wqmf_pkg::MET_W-1:0]           r_o_dev;
    logic [wqmf_pkg::MET_W-1:0]           r_o_crit;

    logic                                 c_acc_en;
    logic [CW-1:0]                        c_cnt_next;
    logic signed [wqmf_pkg::SAMPLE_W-1:0] x_vec [WIN];
    logic signed [wqmf_pkg::SAMPLE_W-1:0] tap_x;
    logic signed [wqmf_pkg::SAMPLE_W-1:0] x_centre;
    logic [TW-1:0]                        off_full;
    logic [1:0]                           w_idx;
    logic signed [wqmf_pkg::SAMPLE_W:0]   dev_diff;
    logic signed [wqmf_pkg::SAMPLE_W:0]   rgh_diff;
    logic signed [wqmf_pkg::SAMPLE_W:0]   ma_op;
    logic signed [2*wqmf_pkg::SAMPLE_W+1:0] ma_prod;
    logic [wqmf_pkg::MB_A_W-1:0]          mb_a;
    logic [wqmf_pkg::CFG_W-1:0]           mb_b;
    logic [wqmf_pkg::PROD_W-1:0]          mb_prod;
    logic [wqmf_pkg::CFG_W-1:0]           lam;
    logic [wqmf_pkg::SUM_W-1:0]           trial;
    logic [CW-1:0]                        div_n;
    logic [CW:0]                          rem_sh;
    logic                                 out_free;

    assign c_acc_en   = r_count < CNT_MAX;
    assign c_cnt_next = c_acc_en ? r_count + CW'(1) : r_count;

    always_comb begin
        x_vec[0] = r_sample;
        for (int i = 1; i < WIN; i++) begin
            x_vec[i] = r_window[i-1];
        end
    end

    assign tap_x    = x_vec[r_tap];
    assign x_centre = x_vec[HALF];
    assign off_full = (r_tap > TW'(HALF)) ? r_tap - TW'(HALF) : TW'(HALF) - r_tap;
    assign w_idx    = 2'(off_full);

    assign dev_diff = $signed({2'b00, r_y}) - $signed({x_centre[wqmf_pkg::SAMPLE_W-1], x_centre});
    assign rgh_diff = $signed({2'b00, r_y}) - $signed({2'b00, r_prev});

    // signed squarer shared by taps and metric terms
    always_comb begin
        unique case (i_op)
            wqmf_pkg::OP_DEV_SQ:  ma_op = dev_diff;
            wqmf_pkg::OP_DEV_ADD: ma_op = rgh_diff;
            default:              ma_op = {tap_x[wqmf_pkg::SAMPLE_W-1], tap_x};
        endcase
    end
    assign ma_prod = ma_op * ma_op;

    assign lam = (i_cfg.lambda > wqmf_pkg::ONE_Q16) ? wqmf_pkg::ONE_Q16 : i_cfg.lambda;

    // unsigned multiplier shared by weighting and criterion blend
    always_comb begin
        unique case (i_op)
            wqmf_pkg::OP_CRIT1: begin
                mb_a = wqmf_pkg::MB_A_W'(r_rough);
                mb_b = lam;
            end
            wqmf_pkg::OP_CRIT2: begin
                mb_a = wqmf_pkg::MB_A_W'(r_dev);
                mb_b = wqmf_pkg::ONE_Q16 - lam;
            end
            default: begin
                mb_a = r_sq[wqmf_pkg::MB_A_W-1:0];
                mb_b = i_cfg.weight[w_idx];
            end
        endcase
    end
    assign mb_prod = mb_a * mb_b;

    assign trial  = r_root + r_bit;
    assign div_n  = r_cnt_next - CNT_WIN + CW'(1);
    assign rem_sh = {r_rem, r_quo[wqmf_pkg::SUM_W-1]};

    assign out_free = !r_out_valid || i_out_ready;

    // record state and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN - 1; i++) begin
                r_window[i] <= '0;
            end
            r_count      <= '0;
            r_prev       <= '0;
            r_prev_valid <= 1'b0;
            r_rsum       <= '0;
            r_dsum       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            unique case (i_op)
                wqmf_pkg::OP_DEV_ADD: begin
                    r_dsum <= wqmf_pkg::sat_add48(r_dsum, wqmf_pkg::SUM_W'(r_sq));
                end
                wqmf_pkg::OP_RGH_ADD: begin
                    if (r_prev_valid) begin
                        r_rsum <= wqmf_pkg::sat_add48(r_rsum, wqmf_pkg::SUM_W'(r_sq));
                    end
                end
                wqmf_pkg::OP_EMIT: begin
                    r_out_valid <= 1'b1;
                    if (r_last) begin
                        for (int i = 0; i < WIN - 1; i++) begin
                            r_window[i] <= '0;
                        end
                        r_count      <= '0;
                        r_prev       <= '0;
                        r_prev_valid <= 1'b0;
                        r_rsum       <= '0;
                        r_dsum       <= '0;
                    end else begin
                        r_window[0] <= r_sample;
                        for (int i = 1; i < WIN - 1; i++) begin
                            r_window[i] <= r_window[i-1];
                        end
                        r_count <= r_cnt_next;
                        if (r_full) begin
                            r_prev       <= r_y;
                            r_prev_valid <= 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // arithmetic working registers
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            wqmf_pkg::OP_LOAD: begin
                r_sample   <= $signed(i_sample);
                r_last     <= i_last;
                r_acc_en   <= c_acc_en;
                r_cnt_next <= c_cnt_next;
                r_full     <= c_cnt_next >= CNT_WIN;
                r_tap      <= '0;
                r_acc      <= '0;
                r_prod     <= '0;
                r_y        <= '0;
                r_rough    <= '0;
                r_dev      <= '0;
                r_crit     <= '0;
            end
            wqmf_pkg::OP_SQ: begin
                r_sq  <= ma_prod[wqmf_pkg::SQ_W-1:0];
                r_acc <= r_acc + wqmf_pkg::ACC_W'(r_prod);
            end
            wqmf_pkg::OP_WT: begin
                r_prod <= mb_prod;
                r_tap  <= r_tap + TW'(1);
            end
            wqmf_pkg::OP_ACC: begin
                r_acc <= r_acc + wqmf_pkg::ACC_W'(r_prod);
            end
            wqmf_pkg::OP_FSQRT_LD: begin
                r_rad  <= wqmf_pkg::SUM_W'(r_acc[wqmf_pkg::ACC_W-1:wqmf_pkg::Q_SHIFT]);
                r_root <= '0;
                r_bit  <= wqmf_pkg::SUM_W'(1) << wqmf_pkg::FILT_SQRT_TOP;
            end
            wqmf_pkg::OP_RSQRT_LD: begin
                r_rad  <= r_rsum;
                r_root <= '0;
                r_bit  <= wqmf_pkg::SUM_W'(1) << wqmf_pkg::WIDE_SQRT_TOP;
            end
            wqmf_pkg::OP_DSQRT_LD: begin
                r_rad  <= r_quo;
                r_root <= '0;
                r_bit  <= wqmf_pkg::SUM_W'(1) << wqmf_pkg::WIDE_SQRT_TOP;
            end
            wqmf_pkg::OP_SQRT_STEP: begin
                if (r_rad >= trial) begin
                    r_rad  <= r_rad - trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            wqmf_pkg::OP_FILT_DONE: begin
                r_y <= (r_root > wqmf_pkg::SUM_W'(wqmf_pkg::FILT_MAX)) ?
                       wqmf_pkg::FILT_MAX : r_root[wqmf_pkg::FILT_W-1:0];
            end
            wqmf_pkg::OP_DEV_SQ: begin
                r_sq <= ma_prod[wqmf_pkg::SQ_W-1:0];
            end
            wqmf_pkg::OP_DEV_ADD: begin
                r_sq <= ma_prod[wqmf_pkg::SQ_W-1:0];
            end
            wqmf_pkg::OP_ROUGH_DONE: begin
                r_rough <= (r_root > wqmf_pkg::SUM_W'(wqmf_pkg::MET_MAX)) ?
                           wqmf_pkg::MET_MAX : r_root[wqmf_pkg::MET_W-1:0];
            end
            wqmf_pkg::OP_DIV_LD: begin
                r_quo     <= r_dsum;
                r_rem     <= '0;
                r_div_cnt <= '0;
            end
            wqmf_pkg::OP_DIV_STEP: begin
                // restoring division, one quotient bit a cycle
                if (rem_sh >= {1'b0, div_n}) begin
                    r_rem <= CW'(rem_sh - {1'b0, div_n});
                    r_quo <= {r_quo[wqmf_pkg::SUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[CW-1:0];
                    r_quo <= {r_quo[wqmf_pkg::SUM_W-2:0], 1'b0};
                end
                r_div_cnt <= r_div_cnt + wqmf_pkg::DIV_CNT_W'(1);
            end
            wqmf_pkg::OP_DEV_DONE: begin
                r_dev <= (r_root > wqmf_pkg::SUM_W'(wqmf_pkg::MET_MAX)) ?
                         wqmf_pkg::MET_MAX : r_root[wqmf_pkg::MET_W-1:0];
            end
            wqmf_pkg::OP_CRIT1: begin
                r_acc  <= wqmf_pkg::CRIT_ROUND;
                r_prod <= mb_prod;
            end
            wqmf_pkg::OP_CRIT2: begin
                r_acc  <= r_acc + wqmf_pkg::ACC_W'(r_prod);
                r_prod <= mb_prod;
            end
            wqmf_pkg::OP_CRIT3: begin
                r_acc <= r_acc + wqmf_pkg::ACC_W'(r_prod);
            end
            wqmf_pkg::OP_CRIT_DONE: begin
                r_crit <= (r_acc[wqmf_pkg::ACC_W-1:wqmf_pkg::Q_SHIFT] >
                           (wqmf_pkg::ACC_W - wqmf_pkg::Q_SHIFT)'(wqmf_pkg::MET_MAX)) ?
                          wqmf_pkg::MET_MAX :
                          r_acc[wqmf_pkg::Q_SHIFT+wqmf_pkg::MET_W-1:wqmf_pkg::Q_SHIFT];
            end
            wqmf_pkg::OP_EMIT: begin
                r_o_filt   <= r_y;
                r_o_fvalid <= r_full;
                r_o_mvalid <= r_last;
                r_o_rough  <= r_rough;
                r_o_dev    <= r_dev;
                r_o_crit   <= r_crit;
            end
            default: begin
            end
        endcase
    end

    assign o_status.tap_last  = r_tap == TW'(WIN - 1);
    assign o_status.sqrt_done = r_bit == '0;
    assign o_status.div_done  = r_div_cnt == wqmf_pkg::DIV_CNT_W'(wqmf_pkg::SUM_W);
    assign o_status.full      = r_full;
    assign o_status.last      = r_last;
    assign o_status.acc_en    = r_acc_en;
    assign o_status.out_free  = out_free;

    assign o_out_valid  = r_out_valid;
    assign o_filtered   = r_o_filt;
    assign o_filt_valid = r_o_fvalid;
    assign o_met_valid  = r_o_mvalid;
    assign o_rough      = r_o_rough;
    assign o_dev        = r_o_dev;
    assign o_crit       = r_o_crit;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_out_valid && !i_out_ready && i_op == wqmf_pkg::OP_EMIT))
        else $error("output register overwritten while still held");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("sample count above its ceiling");
    a_prev_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prev_valid |-> (r_count >= CNT_WIN))
        else $error("previous output marked valid before a full window");
`endif

endmodule

// ===== rtl/weighted_quadratic_mean_filter_unit.sv =====
// Weighted quadratic mean sliding-window filter with record smoothness metrics.
// Slave stream: tdata[15:0] signed Q4.12 sample, tlast marks the last sample
// of a record. Master stream: one result per request, see tdata/tuser below.
// Config port: write enable, register index (0 centre weight, 1..3 offset
// weights, 4 lambda), 17-bit data, taken when enable is high outside reset.
// Sequence: the sample is loaded, each tap is squared and weighted in turn and
// summed; a full window adds the filter square root (17 steps) and, below the
// sample limit, the deviation and roughness sums. A last sample with a full
// window adds two 24-step roots, a 48-step divider and the criterion blend.
// The controller handles one request at a time, each emitted before the next.
// The result sits in an output register; the next request is accepted while
// it waits, and the block only stalls when a new result is ready before the
// previous one has been taken.
// Reset clears the window, sample count, sums and output valid and restores
// the register defaults.
module weighted_quadratic_mean_filter_unit #(
    parameter int unsigned TAPS        = 3,
    parameter int unsigned MAX_SAMPLES = 1024
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    input  logic [wqmf_pkg::IN_TDATA_W-1:0]         i_s_axis_tdata,  // sample
    input  logic                                    i_s_axis_tlast,
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    // filtered, roughness, deviation, criterion, zero pad
    output logic [wqmf_pkg::OUT_TDATA_W-1:0]        o_m_axis_tdata,
    // filtered_valid, metrics_valid
    output logic [wqmf_pkg::OUT_TUSER_W-1:0]        o_m_axis_tuser,
    input  logic                                    i_cfg_we,
    input  logic [wqmf_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [wqmf_pkg::CFG_W-1:0]              i_cfg_wdata
);

    wqmf_pkg::t_cfg         cfg;
    wqmf_pkg::t_dp_status   status;
    wqmf_pkg::t_dp_op       op;
    logic [wqmf_pkg::FILT_W-1:0] filtered;
    logic                        filt_valid;
    logic                        met_valid;
    logic [wqmf_pkg::MET_W-1:0]  rough;
    logic [wqmf_pkg::MET_W-1:0]  dev;
    logic [wqmf_pkg::MET_W-1:0]  crit;

    wqmf_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    wqmf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_status   (status),
        .o_in_ready (o_s_axis_tready),
        .o_op       (op)
    );

    wqmf_datapath #(
        .TAPS        (TAPS),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (op),
        .i_cfg        (cfg),
        .i_sample     (i_s_axis_tdata),
        .i_last       (i_s_axis_tlast),
        .i_out_ready  (i_m_axis_tready),
        .o_status     (status),
        .o_out_valid  (o_m_axis_tvalid),
        .o_filtered   (filtered),
        .o_filt_valid (filt_valid),
        .o_met_valid  (met_valid),
        .o_rough      (rough),
        .o_dev        (dev),
        .o_crit       (crit)
    );

    assign o_m_axis_tdata = {1'b0, crit, dev, rough, filtered};
    assign o_m_axis_tuser = {met_valid, filt_valid};

endmodule

// ===== sim/weighted_quadratic_mean_filter_unit_tb.sv =====
// self-checking testbench for the weighted quadratic mean filter unit: a scoreboard
// class predicts every result from the accepted requests and compares it field by field
// depends on wqmf_pkg and weighted_quadratic_mean_filter_unit only
module weighted_quadratic_mean_filter_unit_tb;
    import wqmf_pkg::*;

    localparam int unsigned TAPS        = 3;
    localparam int unsigned MAX_SAMPLES = 1024;
    localparam int unsigned HALF        = (TAPS - 1) / 2;
    localparam int unsigned WIN         = 2 * HALF + 1;
    localparam int unsigned NUM_REGS    = 5;
    localparam int unsigned SETTLE      = 200;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam longint unsigned SUM_CAP = (64'd1 << SUM_W) - 1;

    typedef struct {
        logic [FILT_W-1:0] filtered;
        logic              filtered_valid;
        logic              metrics_valid;
        logic [MET_W-1:0]  roughness;
        logic [MET_W-1:0]  deviation;
        logic [MET_W-1:0]  criterion;
    } filter_result_t;

    class filter_scoreboard;
        logic [CFG_W-1:0]           setting [NUM_REGS];
        logic signed [SAMPLE_W-1:0] history [WIN-1];
        int unsigned                count;
        logic [FILT_W-1:0]          prev_filtered;
        bit                         prev_valid;
        longint unsigned            rough_acc;
        longint unsigned            dev_acc;
        filter_result_t             expected_q [$];
        int unsigned                mismatches;

        function new();
            setting[REG_W_CENTER] = W_CENTER_RST;
            setting[REG_W_OFF1]   = W_OFF1_RST;
            setting[REG_W_OFF2]   = W_OFF2_RST;
            setting[REG_W_OFF3]   = W_OFF3_RST;
            setting[REG_LAMBDA]   = LAMBDA_RST;
            mismatches = 0;
            clear_record();
        endfunction

        function void clear_record();
            for (int i = 0; i < WIN - 1; i++) history[i] = '0;
            count = 0;
            prev_filtered = '0;
            prev_valid = 1'b0;
            rough_acc = 0;
            dev_acc = 0;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
            setting[idx] = val;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function longint unsigned root_floor(input longint unsigned v);
            longint unsigned res, trial;
            res = 0;
            for (int b = 31; b >= 0; b--) begin
                trial = res | (64'd1 << b);
                if (trial * trial <= v) res = trial;
            end
            return res;
        endfunction

        function longint unsigned add_sat(input longint unsigned a, input longint unsigned b);
            longint unsigned s;
            s = a + b;
            return (s > SUM_CAP || s < a) ? SUM_CAP : s;
        endfunction

        function longint unsigned cap24(input longint unsigned v);
            return (v > MET_MAX) ? MET_MAX : v;
        endfunction

        // predicts the result of one accepted request
        function void note_sample(input logic [SAMPLE_W-1:0] raw, input logic is_last);
            logic signed [SAMPLE_W-1:0] taps [WIN];
            longint unsigned wsum, y, rough, dev, lam, crit, n;
            longint          sq, diff;
            int unsigned     count_next;
            bit              acc_on, full;
            filter_result_t  r;
            taps[0] = raw;
            for (int i = 1; i < WIN; i++) taps[i] = history[i-1];
            acc_on = count < MAX_SAMPLES;
            count_next = acc_on ? count + 1 : count;
            full = count_next >= WIN;
            wsum = 0;
            y = 0;
            if (full) begin
                for (int i = 0; i < WIN; i++) begin
                    sq = longint'(taps[i]) * longint'(taps[i]);
                    wsum += longint'(sq) * setting[(i > HALF) ? i - HALF : HALF - i];
                end
                y = root_floor(wsum >> Q_SHIFT);
                if (y > FILT_MAX) y = FILT_MAX;
                if (acc_on) begin
                    diff = longint'(y) - longint'(taps[HALF]);
                    dev_acc = add_sat(dev_acc, diff * diff);
                    if (prev_valid) begin
                        diff = longint'(y) - longint'(prev_filtered);
                        rough_acc = add_sat(rough_acc, diff * diff);
                    end
                end
                prev_filtered = FILT_W'(y);
                prev_valid = 1'b1;
            end
            for (int i = WIN - 2; i > 0; i--) history[i] = history[i-1];
            history[0] = raw;
            count = count_next;

            r.filtered = FILT_W'(y);
            r.filtered_valid = full;
            r.metrics_valid = 1'b0;
            r.roughness = '0;
            r.deviation = '0;
            r.criterion = '0;
            if (is_last) begin
                n = (count_next >= WIN) ? count_next - WIN + 1 : 0;
                rough = cap24(root_floor(rough_acc));
                dev = (n != 0) ? cap24(root_floor(dev_acc / n)) : 0;
                lam = (setting[REG_LAMBDA] > ONE_Q16) ? ONE_Q16 : setting[REG_LAMBDA];
                crit = (lam * rough + (longint'(ONE_Q16) - lam) * dev + CRIT_ROUND) >> Q_SHIFT;
                if (n == 0) begin
                    rough = 0;
                    crit = 0;
                end
                r.metrics_valid = 1'b1;
                r.roughness = MET_W'(rough);
                r.deviation = MET_W'(dev);
                r.criterion = MET_W'(cap24(crit));
                clear_record();
            end
            expected_q.push_back(r);
        endfunction

        function void compare(input string what, input logic [63:0] exp, input logic [63:0] act);
            if (act !== exp) begin
                $error("%s: expected %0d, got %0d", what, exp, act);
                mismatches++;
            end
        endfunction

        function void check_result(input logic [OUT_TDATA_W-1:0] data,
                                   input logic [OUT_TUSER_W-1:0] user);
            filter_result_t e;
            if (expected_q.size() == 0) begin
                $error("result with no request outstanding: tdata %h tuser %b", data, user);
                mismatches++;
                return;
            end
            e = expected_q.pop_front();
            compare("filtered", e.filtered, data[FILT_W-1:0]);
            compare("roughness", e.roughness, data[FILT_W +: MET_W]);
            compare("deviation", e.deviation, data[FILT_W + MET_W +: MET_W]);
            compare("criterion", e.criterion, data[FILT_W + 2*MET_W +: MET_W]);
            compare("filtered_valid", e.filtered_valid, user[0]);
            compare("metrics_valid", e.metrics_valid, user[1]);
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tready = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_idx = REG_W_CENTER;
    logic [CFG_W-1:0]       cfg_wdata = '0;
    wire                    s_tready;
    wire                    m_tvalid;
    wire [OUT_TDATA_W-1:0]  m_tdata;
    wire [OUT_TUSER_W-1:0]  m_tuser;

    bit idle_off = 1'b0;
    bit hold_req = 1'b0;
    filter_scoreboard board;

    weighted_quadratic_mean_filter_unit #(
        .TAPS        (TAPS),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata)
    );

    always #5 clk = ~clk;

    // receiver: random back-pressure, or a long hold-off on request
    initial begin
        forever begin
            @(negedge clk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end else begin
                m_tready <= idle_off || ($urandom_range(99) >= 33);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic is_last);
        if (!idle_off && $urandom_range(99) < 33) begin
            s_tvalid <= 1'b0;
            repeat (($urandom_range(3) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 4))
                @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= smp;
        s_tlast <= is_last;
        do @(posedge clk); while (!s_tready);
        board.note_sample(smp, is_last);
        @(negedge clk);
    endtask

    task automatic send_list(input logic [SAMPLE_W-1:0] list [$]);
        foreach (list[k]) send_sample(list[k], k == list.size() - 1);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic load_settings(input logic [CFG_W-1:0] wc, w1, w2, w3, lam);
        cfg_we <= 1'b1;
        cfg_idx <= REG_W_CENTER;
        cfg_wdata <= wc;
        @(negedge clk);
        cfg_idx <= REG_W_OFF1;
        cfg_wdata <= w1;
        @(negedge clk);
        cfg_idx <= REG_W_OFF2;
        cfg_wdata <= w2;
        @(negedge clk);
        cfg_idx <= REG_W_OFF3;
        cfg_wdata <= w3;
        @(negedge clk);
        cfg_idx <= REG_LAMBDA;
        cfg_wdata <= lam;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.set_reg(REG_W_CENTER, wc);
        board.set_reg(REG_W_OFF1, w1);
        board.set_reg(REG_W_OFF2, w2);
        board.set_reg(REG_W_OFF3, w3);
        board.set_reg(REG_LAMBDA, lam);
    endtask

    function automatic logic [CFG_W-1:0] random_weight();
        case ($urandom_range(5))
            0: return '0;
            1: return ONE_Q16;
            2: return $urandom_range(131071);
            default: return $urandom_range(40000);
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6: return SAMPLE_W'(int'($urandom_range(8192)) - 4096);
            7: return SAMPLE_W'(int'($urandom_range(32768)) - 16384);
            default: begin
                case ($urandom_range(3))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'hffff;
                    default: return 16'h0000;
                endcase
            end
        endcase
    endfunction

    task automatic send_random_records(input int unsigned items);
        int unsigned sent, len;
        sent = 0;
        while (sent < items) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
            for (int k = 0; k < len; k++) send_sample(random_sample(), k == len - 1);
            sent += len;
        end
    endtask

    task automatic random_settings();
        load_settings(random_weight(), random_weight(), random_weight(), random_weight(),
                      random_weight());
    endtask

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        board = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // register defaults: lone last sample, record too short for a window, extremes
        send_list('{16'h7fff});
        send_list('{16'h8000, 16'h0000});
        send_list('{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001, 16'h7fff});
        drain();

        // unit weights and lambda, filtered output saturates
        load_settings(ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16);
        send_list('{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff});
        drain();

        // weights and lambda above one
        load_settings('1, '1, '1, '1, '1);
        send_list('{16'd1000, -16'sd1000, 16'd20000, 16'd5});
        drain();

        load_settings('0, '0, '0, '0, '0);
        send_list('{16'h1234, 16'hedcb, 16'h0fff});
        drain();

        random_settings();
        send_random_records(110);
        drain();

        // stretch with no idling on either side
        random_settings();
        idle_off = 1'b1;
        send_random_records(110);
        drain();
        idle_off = 1'b0;

        // long receiver hold-off while requests keep coming, then a full pause
        random_settings();
        hold_req = 1'b1;
        for (int k = 0; k < 12; k++) send_sample(random_sample(), k == 11);
        drain();
        send_random_records(100);
        drain();

        random_settings();
        send_random_records(110);
        drain();

        random_settings();
        send_random_records(110);
        drain();

        // record longer than the sample limit
        random_settings();
        for (int k = 0; k < MAX_SAMPLES + 6; k++)
            send_sample(random_sample(), k == MAX_SAMPLES + 5);
        drain();

        if (board.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/wqmf_pkg.sv
rtl/wqmf_cfg_regs.sv
rtl/wqmf_ctrl.sv
rtl/wqmf_datapath.sv
rtl/weighted_quadratic_mean_filter_unit.sv
sim/weighted_quadratic_mean_filter_unit_tb.sv
